// ----- hdl/sfcs_pkg.sv -----
package sfcs_pkg;

    // page size for program requests
    localparam int unsigned PAGE_BYTES = 256;

    // poll limit and busy mask after reset
    localparam logic [31:0] POLL_LIMIT_RESET = 32'hEFFF_FFFF;
    localparam logic [7:0]  BUSY_MASK_RESET  = 8'h01;

    // register indexes on the configuration port
    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_BUSY_MASK  = 1'b1;

    // flash opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] OP_CE    = 8'hC7;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_JEDEC = 8'h9F;
    localparam logic [7:0] OP_PD    = 8'hB9;
    localparam logic [7:0] OP_WAKE  = 8'hAB;

    // bytes returned by a jedec id read
    localparam logic [15:0] JEDEC_BYTES = 16'd3;

    // request kinds
    typedef enum logic [3:0] {
        KIND_JEDEC  = 4'd0,
        KIND_READ   = 4'd1,
        KIND_PROG   = 4'd2,
        KIND_SECTOR = 4'd3,
        KIND_CHIP   = 4'd4,
        KIND_PDOWN  = 4'd5,
        KIND_WAKE   = 4'd6,
        KIND_STATUS = 4'd7,
        KIND_NONE   = 4'd8
    } kind_t;

    // result event codes
    typedef enum logic [1:0] {
        EV_FRAME   = 2'd0,
        EV_DONE    = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    // busy wait phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRE  = 2'd1,
        PH_POST = 2'd2
    } phase_t;

    // one accepted input item
    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  status_value;
    } item_t;

    // one result without its last mark
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  opcode;
        logic [23:0] frame_address;
        logic        has_address;
        logic [8:0]  write_count;
        logic [15:0] read_count;
        logic        clamped;
    } res_t;

    // sequencer state kept between items
    typedef struct packed {
        phase_t      phase;
        logic [23:0] held_address;
        logic [31:0] poll_count;
    } seq_state_t;

    localparam int unsigned MAX_RES = 3;

    function automatic res_t mk_frame(input logic [7:0] op, input logic [23:0] addr,
                                      input logic has, input logic [8:0] wc,
                                      input logic [15:0] rc, input logic clp);
        res_t r;
        r.event_res     = EV_FRAME;
        r.opcode        = op;
        r.frame_address = has ? addr : 24'd0;
        r.has_address   = has;
        r.write_count   = wc;
        r.read_count    = rc;
        r.clamped       = clp;
        return r;
    endfunction

    function automatic res_t mk_event(input event_t ev);
        res_t r;
        r               = '0;
        r.event_res     = ev;
        return r;
    endfunction

endpackage

// ----- hdl/serial_flash_command_sequencer.sv -----
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tuser kind, s_tdata address/length/status_value
// m_        out  m_tvalid/m_tready    m_tuser event_res, m_tdata frame fields, m_tlast
// cfg_wr_   in   cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// an item sits in the input register, is decoded combinationally into zero to three
// results that are loaded into the output buffer and leave one per cycle while
// m_tready is high. items with at most one result flow at one per cycle while
// m_tready is high, else the next item waits for the last result. synchronous
// active-low reset clears state and both buffers; stalls on m_ back up s_tready.
module serial_flash_command_sequencer import sfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // address[23:0], length[39:24], status_value[47:40]
    input  logic [3:0]  s_tuser,    // kind[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // opcode[7:0], frame_address[31:8], has_address[32],
                                    // write_count[41:33], read_count[57:42], clamped[58]
    output logic [1:0]  m_tuser,    // event_res[1:0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [31:0] cfg_wr_data
);

    logic        in_vld_reg;
    item_t       in_item_reg;
    logic        consume;
    logic        buf_free;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic [31:0] poll_limit_reg;
    logic [7:0]  busy_mask_reg;
    res_t        dec_res [MAX_RES];
    logic [1:0]  dec_count;
    res_t        out_res;

    assign consume  = in_vld_reg && buf_free;
    assign s_tready = !in_vld_reg || consume;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= POLL_LIMIT_RESET;
            busy_mask_reg  <= BUSY_MASK_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_POLL_LIMIT) begin
                poll_limit_reg <= cfg_wr_data;
            end else begin
                busy_mask_reg <= cfg_wr_data[7:0];
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.address      <= s_tdata[23:0];
            in_item_reg.length       <= s_tdata[39:24];
            in_item_reg.status_value <= s_tdata[47:40];
        end
    end

    // sequencer state, updated as each item is decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.held_address <= 24'd0;
            state_reg.poll_count   <= 32'd0;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

    sfcs_decode u_decode (
        .item       (in_item_reg),
        .state      (state_reg),
        .poll_limit (poll_limit_reg),
        .busy_mask  (busy_mask_reg),
        .res        (dec_res),
        .res_count  (dec_count),
        .state_next (state_next)
    );

    sfcs_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume),
        .load_res   (dec_res),
        .load_count (dec_count),
        .free       (buf_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (out_res),
        .m_tlast    (m_tlast)
    );

    // result packing
    assign m_tuser = out_res.event_res;
    assign m_tdata = {5'd0, out_res.clamped, out_res.read_count, out_res.write_count,
                      out_res.has_address, out_res.frame_address, out_res.opcode};

endmodule

// ----- hdl/sfcs_decode.sv -----
module sfcs_decode import sfcs_pkg::*; (
    input  item_t       item,
    input  seq_state_t  state,
    input  logic [31:0] poll_limit,
    input  logic [7:0]  busy_mask,
    output res_t        res [MAX_RES],
    output logic [1:0]  res_count,
    output seq_state_t  state_next
);

    localparam logic [16:0] PAGE_LEN = 17'(PAGE_BYTES);

    logic        fresh_timeout;
    logic        cont_timeout;
    logic        busy;
    logic        page_over;
    logic [8:0]  prog_count;
    res_t        fresh_poll;
    res_t        cont_poll;

    // a fresh wait starts counting at zero, a running one from the stored count
    assign fresh_timeout = (poll_limit == 32'd0);
    assign cont_timeout  = (state.poll_count >= poll_limit);
    assign fresh_poll    = fresh_timeout ? mk_event(EV_TIMEOUT)
                                         : mk_frame(OP_RDSR, 24'd0, 1'b0, 9'd0, 16'd1, 1'b0);
    assign cont_poll     = cont_timeout ? mk_event(EV_TIMEOUT)
                                        : mk_frame(OP_RDSR, 24'd0, 1'b0, 9'd0, 16'd1, 1'b0);

    // busy when every masked bit is set
    assign busy = ((item.status_value & busy_mask) == busy_mask);

    // page program length clamp
    assign page_over  = ({1'b0, item.length} > PAGE_LEN);
    assign prog_count = page_over ? PAGE_LEN[8:0] : item.length[8:0];

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end
        res_count  = 2'd0;
        state_next = state;
        if (state.phase == PH_IDLE) begin
            unique case (item.kind)
                KIND_JEDEC: begin
                    res[0]    = mk_frame(OP_JEDEC, 24'd0, 1'b0, 9'd0, JEDEC_BYTES, 1'b0);
                    res_count = 2'd1;
                end
                KIND_READ: begin
                    res[0]    = mk_frame(OP_READ, item.address, 1'b1, 9'd0, item.length, 1'b0);
                    res_count = 2'd1;
                end
                KIND_PROG: begin
                    res[0]    = mk_frame(OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res[1]    = mk_frame(OP_PP, item.address, 1'b1, prog_count, 16'd0,
                                         page_over);
                    res[2]    = fresh_poll;
                    res_count = 2'd3;
                    state_next.phase      = fresh_timeout ? PH_IDLE : PH_POST;
                    state_next.poll_count = fresh_timeout ? 32'd0 : 32'd1;
                end
                KIND_SECTOR: begin
                    res[0]    = mk_frame(OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res[1]    = fresh_poll;
                    res_count = 2'd2;
                    state_next.held_address = item.address;
                    state_next.phase        = fresh_timeout ? PH_IDLE : PH_PRE;
                    state_next.poll_count   = fresh_timeout ? 32'd0 : 32'd1;
                end
                KIND_CHIP: begin
                    res[0]    = mk_frame(OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res[1]    = mk_frame(OP_CE, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res[2]    = fresh_poll;
                    res_count = 2'd3;
                    state_next.phase      = fresh_timeout ? PH_IDLE : PH_POST;
                    state_next.poll_count = fresh_timeout ? 32'd0 : 32'd1;
                end
                KIND_PDOWN: begin
                    res[0]    = mk_frame(OP_PD, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res_count = 2'd1;
                end
                KIND_WAKE: begin
                    res[0]    = mk_frame(OP_WAKE, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    res_count = 2'd1;
                end
                default: begin
                    res_count = 2'd0;
                end
            endcase
        end else if (item.kind == KIND_STATUS) begin
            // status byte during a wait
            if (busy) begin
                res[0]    = cont_poll;
                res_count = 2'd1;
                if (cont_timeout) begin
                    state_next.phase = PH_IDLE;
                end else begin
                    state_next.poll_count = state.poll_count + 32'd1;
                end
            end else if (state.phase == PH_PRE) begin
                res[0]    = mk_frame(OP_SE, state.held_address, 1'b1, 9'd0, 16'd0, 1'b0);
                res[1]    = fresh_poll;
                res_count = 2'd2;
                state_next.phase      = fresh_timeout ? PH_IDLE : PH_POST;
                state_next.poll_count = fresh_timeout ? 32'd0 : 32'd1;
            end else begin
                res[0]    = mk_event(EV_DONE);
                res_count = 2'd1;
                state_next.phase = PH_IDLE;
            end
        end
    end

endmodule

// ----- hdl/sfcs_out_buf.sv -----
module sfcs_out_buf import sfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  res_t        load_res [MAX_RES],
    input  logic [1:0]  load_count,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output res_t        m_res,
    output logic        m_tlast
);

    res_t       res_reg [MAX_RES];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign take     = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_res    = res_reg[idx_reg];
    // free for a new set when empty or the last result leaves now
    assign free     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    // remaining count and read position
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = load_count;
            idx_next = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                res_reg[i] <= load_res[i];
            end
        end
    end

endmodule

// ----- sim/tb_serial_flash_command_sequencer.sv -----
`timescale 1ns / 1ps

module tb_serial_flash_command_sequencer;
    import sfcs_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;

    // one expected result with its last mark
    typedef struct {
        res_t res;
        logic last;
    } frame_exp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;      // address[23:0], length[39:24], status_value[47:40]
    logic [3:0]  s_tuser = '0;      // kind[3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // opcode[7:0], frame_address[31:8], has_address[32],
                                    // write_count[41:33], read_count[57:42], clamped[58]
    logic [1:0]  m_tuser;           // event_res[1:0]
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    serial_flash_command_sequencer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // requests waiting to be sent and frames the sequencer still owes
    item_t      flash_items_q[$];
    frame_exp_t frames_due[$];
    item_t      cur_item;

    // sequencer state as predicted from the accepted items
    phase_t      pred_phase = PH_IDLE;
    logic [23:0] pred_sector = '0;
    logic [31:0] pred_polls = '0;
    logic [31:0] cur_poll_limit = POLL_LIMIT_RESET;
    logic [7:0]  cur_busy_mask = BUSY_MASK_RESET;

    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int stall_cycles = 0;

    int n_errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_done = 0;
    int n_timeouts = 0;
    int n_clamped = 0;
    int n_settings = 1;

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // append one expected result
    function automatic void owe_frame(event_t ev, logic [7:0] op, logic [23:0] addr,
                                      logic has, logic [8:0] wc, logic [15:0] rc,
                                      logic clp);
        frame_exp_t e;
        e.res.event_res     = ev;
        e.res.opcode        = op;
        e.res.frame_address = has ? addr : 24'd0;
        e.res.has_address   = has;
        e.res.write_count   = wc;
        e.res.read_count    = rc;
        e.res.clamped       = clp;
        e.last              = 1'b0;
        frames_due.push_back(e);
    endfunction

    // next status poll, or a timeout once the limit is used up
    function automatic void owe_poll(phase_t wait_ph);
        if (pred_polls >= cur_poll_limit) begin
            pred_phase = PH_IDLE;
            owe_frame(EV_TIMEOUT, 8'd0, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
        end else begin
            pred_polls = pred_polls + 32'd1;
            pred_phase = wait_ph;
            owe_frame(EV_FRAME, OP_RDSR, 24'd0, 1'b0, 9'd0, 16'd1, 1'b0);
        end
    endfunction

    function automatic void start_busy_wait(phase_t wait_ph);
        pred_polls = '0;
        owe_poll(wait_ph);
    endfunction

    // expected frames and events for one accepted item
    function automatic void sequence_item(item_t it);
        int         n0;
        frame_exp_t e;
        logic [8:0] wc;
        logic       clp;
        logic       busy;
        n0 = frames_due.size();
        if (pred_phase == PH_IDLE) begin
            case (it.kind)
                KIND_JEDEC: owe_frame(EV_FRAME, OP_JEDEC, 24'd0, 1'b0, 9'd0, JEDEC_BYTES, 1'b0);
                KIND_READ: owe_frame(EV_FRAME, OP_READ, it.address, 1'b1, 9'd0, it.length, 1'b0);
                KIND_PROG: begin
                    clp = (it.length > PAGE_BYTES);
                    wc  = clp ? 9'(PAGE_BYTES) : it.length[8:0];
                    owe_frame(EV_FRAME, OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    owe_frame(EV_FRAME, OP_PP, it.address, 1'b1, wc, 16'd0, clp);
                    start_busy_wait(PH_POST);
                end
                KIND_SECTOR: begin
                    pred_sector = it.address;
                    owe_frame(EV_FRAME, OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    start_busy_wait(PH_PRE);
                end
                KIND_CHIP: begin
                    owe_frame(EV_FRAME, OP_WREN, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    owe_frame(EV_FRAME, OP_CE, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                    start_busy_wait(PH_POST);
                end
                KIND_PDOWN: owe_frame(EV_FRAME, OP_PD, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                KIND_WAKE: owe_frame(EV_FRAME, OP_WAKE, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
                default: ;
            endcase
        end else if (it.kind == KIND_STATUS) begin
            busy = ((it.status_value & cur_busy_mask) == cur_busy_mask);
            if (busy) begin
                owe_poll(pred_phase);
            end else if (pred_phase == PH_PRE) begin
                owe_frame(EV_FRAME, OP_SE, pred_sector, 1'b1, 9'd0, 16'd0, 1'b0);
                start_busy_wait(PH_POST);
            end else begin
                pred_phase = PH_IDLE;
                owe_frame(EV_DONE, 8'd0, 24'd0, 1'b0, 9'd0, 16'd0, 1'b0);
            end
        end
        // mark the final result of this item
        if (frames_due.size() > n0) begin
            e = frames_due.pop_back();
            e.last = 1'b1;
            frames_due.push_back(e);
        end
    endfunction

    // input driver, predicts each item as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sequence_item(cur_item);
                n_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && flash_items_q.size() > 0
                             && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(1, 16) - 1;
                    s_tvalid <= 1'b0;
                end else if (flash_items_q.size() > 0) begin
                    cur_item = flash_items_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.status_value, cur_item.length, cur_item.address};
                    s_tuser  <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        res_t       got;
        frame_exp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.event_res     = event_t'(m_tuser);
                got.opcode        = m_tdata[7:0];
                got.frame_address = m_tdata[31:8];
                got.has_address   = m_tdata[32];
                got.write_count   = m_tdata[41:33];
                got.read_count    = m_tdata[57:42];
                got.clamped       = m_tdata[58];
                n_results++;
                if (frames_due.size() == 0) begin
                    if (n_errors < 10)
                        $display("ERROR: unexpected result ev=%0d op=%h addr=%h last=%b",
                                 got.event_res, got.opcode, got.frame_address, m_tlast);
                    n_errors++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.event_res == EV_DONE) n_done++;
                    if (got.event_res == EV_TIMEOUT) n_timeouts++;
                    if (got.clamped) n_clamped++;
                    if (got.event_res !== want.res.event_res
                        || got.opcode !== want.res.opcode
                        || got.frame_address !== want.res.frame_address
                        || got.has_address !== want.res.has_address
                        || got.write_count !== want.res.write_count
                        || got.read_count !== want.res.read_count
                        || got.clamped !== want.res.clamped
                        || m_tlast !== want.last) begin
                        if (n_errors < 10) begin
                            $display("ERROR: result %0d mismatch", n_results);
                            $display("exp ev=%0d op=%h addr=%h has=%b wc=%0d rc=%0d clp=%b last=%b",
                                     want.res.event_res, want.res.opcode,
                                     want.res.frame_address, want.res.has_address,
                                     want.res.write_count, want.res.read_count,
                                     want.res.clamped, want.last);
                            $display("got ev=%0d op=%h addr=%h has=%b wc=%0d rc=%0d clp=%b last=%b",
                                     got.event_res, got.opcode, got.frame_address,
                                     got.has_address, got.write_count, got.read_count,
                                     got.clamped, m_tlast);
                        end
                        n_errors++;
                    end
                end
            end
            // long hold-off on request, otherwise random stall bursts when idling is enabled
            if (hold_served != hold_req) begin
                hold_served = hold_req;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles, %0d results still due",
                     STALL_LIMIT, frames_due.size());
            $display("** serial_flash_command_sequencer: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_item(input logic [3:0] kind, input logic [23:0] addr,
                              input logic [15:0] len, input logic [7:0] st);
        item_t it;
        it.kind         = kind;
        it.address      = addr;
        it.length       = len;
        it.status_value = st;
        flash_items_q.push_back(it);
    endtask

    // status byte that reads busy or not busy under the current mask
    function automatic logic [7:0] status_byte(input logic busy);
        logic [7:0] s;
        s = 8'($urandom_range(0, 255));
        if (busy)
            return s | cur_busy_mask;
        if (cur_busy_mask == 8'd0)
            return s;
        while ((s & cur_busy_mask) == cur_busy_mask)
            s = 8'($urandom_range(0, 255));
        return s;
    endfunction

    function automatic logic [15:0] rand_length();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 300));
    endfunction

    task automatic queue_status(input logic busy);
        queue_item(KIND_STATUS, 24'($urandom), 16'($urandom), status_byte(busy));
    endtask

    // status replies for one busy wait, sometimes cut short
    task automatic queue_busy_wait(output int cnt);
        int nbusy;
        nbusy = $urandom_range(0, 4);
        cnt = nbusy;
        repeat (nbusy) queue_status(1'b1);
        if ($urandom_range(0, 7) != 0) begin
            queue_status(1'b0);
            cnt++;
        end
    endtask

    // mostly complete request sequences, the rest random noise
    task automatic queue_mix(input int count);
        int         made;
        int         cnt;
        logic [3:0] k;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 8) begin
                k = 4'($urandom_range(0, 6));
                queue_item(k, 24'($urandom), rand_length(), 8'($urandom));
                made++;
                if (k == KIND_PROG || k == KIND_CHIP || k == KIND_SECTOR) begin
                    queue_busy_wait(cnt);
                    made += cnt;
                end
                if (k == KIND_SECTOR) begin
                    queue_busy_wait(cnt);
                    made += cnt;
                end
            end else begin
                queue_item(4'($urandom_range(0, 15)), 24'($urandom), 16'($urandom),
                           8'($urandom));
                made++;
            end
        end
    endtask

    // wait until every item is taken and every result has come back,
    // checked away from the rising edge so the driver's updates have landed
    task automatic drain_all();
        while (flash_items_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (frames_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // finish any busy wait left open so the next setting starts idle
    task automatic settle();
        drain_all();
        while (pred_phase != PH_IDLE) begin
            queue_status(1'b0);
            drain_all();
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        if (idx == CFG_POLL_LIMIT)
            cur_poll_limit = val;
        else
            cur_busy_mask = val[7:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic new_setting(input logic [31:0] limit, input logic [7:0] mask);
        settle();
        write_reg(CFG_POLL_LIMIT, limit);
        write_reg(CFG_BUSY_MASK, {24'd0, mask});
        n_settings++;
    endtask

    // stimulus
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items under the reset settings
        queue_item(KIND_JEDEC, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        queue_item(KIND_READ, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_READ, 24'hFFFFFF, 16'hFFFF, 8'h00);
        queue_item(KIND_PDOWN, 24'h123456, 16'h0010, 8'h00);
        queue_item(KIND_WAKE, 24'h654321, 16'h0020, 8'h00);
        // status while idle and unused kinds are dropped
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h01);
        queue_item(KIND_NONE, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        queue_item(4'hF, 24'hA5A5A5, 16'h5A5A, 8'hA5);
        // full page program, request while waiting is dropped
        queue_item(KIND_PROG, 24'h000100, 16'd256, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'hFF);
        queue_item(KIND_JEDEC, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'hFE);
        // program lengths just over a page and at the top
        queue_item(KIND_PROG, 24'hABCDEF, 16'd257, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_PROG, 24'hFFFFFF, 16'hFFFF, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h01);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h00);
        // sector erase with busy polls before and after the erase
        queue_item(KIND_SECTOR, 24'hFFFFFF, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h01);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h03);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h02);
        queue_item(KIND_CHIP, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_PROG, 24'h000000, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'h00);

        // one poll allowed, every status bit must be set to count as busy
        new_setting(32'd1, 8'hFF);
        queue_item(KIND_PROG, 24'h00F000, 16'd16, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'hFF);
        queue_item(KIND_SECTOR, 24'h0A0000, 16'h0000, 8'h00);
        queue_item(KIND_STATUS, 24'h000000, 16'h0000, 8'hFF);
        queue_mix(40);

        // zero mask: every wait ends in timeout, no idling here
        idle_on = 1'b0;
        new_setting(32'd3, 8'h00);
        queue_mix(30);

        // no practical poll limit, receiver holds off long while items keep coming
        idle_on = 1'b1;
        new_setting(32'hFFFF_FFFF, 8'($urandom_range(1, 255)));
        @(posedge aclk);
        hold_req = hold_req + 1;
        queue_mix(60);

        repeat (3) begin
            new_setting(32'($urandom_range(2, 6)), 8'($urandom_range(1, 255)));
            queue_mix(50);
        end

        // last part without idling
        idle_on = 1'b0;
        new_setting(32'd4, BUSY_MASK_RESET);
        queue_mix(40);
        drain_all();

        $display("run covered %0d items and %0d results over %0d register settings",
                 n_items, n_results, n_settings);
        $display("completions %0d, timeouts %0d, clamped programs %0d, mismatches %0d",
                 n_done, n_timeouts, n_clamped, n_errors);
        if (n_errors == 0) begin
            $display("** serial_flash_command_sequencer: PASSED **");
        end else begin
            $display("** serial_flash_command_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sfcs_pkg.sv
hdl/sfcs_decode.sv
hdl/sfcs_out_buf.sv
hdl/serial_flash_command_sequencer.sv
sim/tb_serial_flash_command_sequencer.sv
